// File: hw/rtl/npst_pkg.sv
// Shared types and constants for the nearest point search table.
package npst_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_W        = 16;
  localparam int ACT_W          = 2;
  localparam int IDX_OUT_W      = 8;
  localparam int DIST_W         = 34;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int TDATA_IN_W     = 48;
  localparam int TDATA_OUT_W    = 48;
  localparam int TUSER_OUT_W    = 2;
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);
  localparam int Q_CW           = $clog2(Q_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } cmd_t;

  typedef struct packed {
    logic                 full;
    logic                 valid;
  } q_stat_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] nearest_index;
    logic                 found;
    logic                 status;
    logic [DIST_W-1:0]    min_dist_sq;
  } res_t;

endpackage

// File: hw/rtl/npst_front.sv
// Front stage: accept input transactions and decode the action into a command.
module npst_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [npst_pkg::TDATA_IN_W-1:0]        in_tdata,
  input  logic [npst_pkg::ACT_W-1:0]             in_tuser,
  input  npst_pkg::q_stat_t                      q_stat,
  output logic                                   q_push,
  output npst_pkg::cmd_t                         q_wdata
);
  import npst_pkg::*;

  logic      hold_v_r, hold_v_nxt;
  cmd_t      hold_r;
  cmd_kind_t kind;

  always_comb begin
    unique case (in_tuser)
      ACT_ADD:   kind = CMD_ADD;
      ACT_FIND:  kind = CMD_FIND;
      ACT_CLEAR: kind = CMD_CLEAR;
      default:   kind = CMD_NOP;
    endcase
  end

  assign q_push    = hold_v_r && !q_stat.full;
  assign q_wdata   = hold_r;
  assign in_tready = !hold_v_r || q_push;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (q_push) hold_v_nxt = 1'b0;
    if (in_tvalid && in_tready) hold_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r.kind    <= kind;
      hold_r.coord_x <= in_tdata[COORD_W-1:0];
      hold_r.coord_y <= in_tdata[2*COORD_W-1:COORD_W];
      hold_r.coord_z <= in_tdata[3*COORD_W-1:2*COORD_W];
    end
  end

endmodule

// File: hw/rtl/npst_queue.sv
// Short command queue between the front and back stages.
module npst_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  npst_pkg::cmd_t    wdata,
  input  logic              pop,
  output npst_pkg::cmd_t    rdata,
  output npst_pkg::q_stat_t stat
);
  import npst_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.valid)
    else $error("queue pop while empty");

endmodule

// File: hw/rtl/npst_back.sv
// Back stage: point store, nearest point scan pipeline and result register.
module npst_back #(
  parameter int MAX_POINTS = npst_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  npst_pkg::q_stat_t                      q_stat,
  input  npst_pkg::cmd_t                         q_rdata,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output npst_pkg::res_t                         res
);
  import npst_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W  = 3 * COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } st_t;

  function automatic logic [COORD_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [IDX_W+IDX_OUT_W-1:0] t;
    t = {{IDX_OUT_W{1'b0}}, i};
    return t[IDX_OUT_W-1:0];
  endfunction

  st_t              st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             res_r, res_nxt;
  logic             have_r, have_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;

  logic [PT_W-1:0]  mem [MAX_POINTS];
  logic [PT_W-1:0]  rd_r;
  logic             we;
  logic             issue;
  logic             out_free;
  logic             full;
  logic             pipe_busy;
  logic             tgt_load;

  logic signed [COORD_W-1:0] tgt_x_r, tgt_y_r, tgt_z_r;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] sum_r;

  assign out_free   = !out_v_r || out_tready;
  assign full       = (cnt_r == CNT_W'(MAX_POINTS));
  assign pipe_busy  = v1_r || v2_r || v3_r || v4_r;
  assign issue      = (st_r == ST_SCAN);
  assign out_tvalid = out_v_r;
  assign res        = res_r;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    out_v_nxt = out_v_r && !out_tready;
    res_nxt   = res_r;
    have_nxt  = have_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    tgt_load  = 1'b0;

    // keep the first minimum: only a strictly smaller distance replaces it
    if (v4_r && (!have_r || sum_r < best_r)) begin
      have_nxt = 1'b1;
      best_nxt = sum_r;
      bidx_nxt = idx4_r;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (q_stat.valid && out_free) begin
          q_pop   = 1'b1;
          res_nxt = '0;
          unique case (q_rdata.kind)
            CMD_ADD: begin
              out_v_nxt = 1'b1;
              if (full) begin
                res_nxt.status = 1'b1;
              end else begin
                we                    = 1'b1;
                res_nxt.nearest_index = idx_out(cnt_r[IDX_W-1:0]);
                res_nxt.found         = 1'b1;
                cnt_nxt               = cnt_r + 1'b1;
              end
            end
            CMD_FIND: begin
              if (cnt_r == '0) begin
                out_v_nxt = 1'b1;
              end else begin
                tgt_load = 1'b1;
                st_nxt   = ST_SCAN;
                scan_nxt = '0;
                have_nxt = 1'b0;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt   = '0;
              out_v_nxt = 1'b1;
            end
            default: begin
              out_v_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == cnt_r - 1'b1) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          res_nxt.nearest_index = idx_out(bidx_r);
          res_nxt.found         = have_r;
          res_nxt.status        = 1'b0;
          res_nxt.min_dist_sq   = best_r;
          out_v_nxt             = 1'b1;
          st_nxt                = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
      have_r  <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
      have_r  <= have_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    if (tgt_load) begin
      tgt_x_r <= q_rdata.coord_x;
      tgt_y_r <= q_rdata.coord_y;
      tgt_z_r <= q_rdata.coord_z;
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[cnt_r[IDX_W-1:0]] <= {q_rdata.coord_z, q_rdata.coord_y, q_rdata.coord_x};
  end

  always_ff @(posedge clk) begin
    rd_r   <= mem[scan_r[IDX_W-1:0]];
    idx1_r <= scan_r[IDX_W-1:0];
  end

  // distance pipeline: abs diff, square, sum
  always_ff @(posedge clk) begin
    ax_r   <= abs_diff(tgt_x_r, rd_r[COORD_W-1:0]);
    ay_r   <= abs_diff(tgt_y_r, rd_r[2*COORD_W-1:COORD_W]);
    az_r   <= abs_diff(tgt_z_r, rd_r[3*COORD_W-1:2*COORD_W]);
    idx2_r <= idx1_r;
    sx_r   <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r   <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r   <= SQ_W'(az_r) * SQ_W'(az_r);
    idx3_r <= idx2_r;
    sum_r  <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
    idx4_r <= idx3_r;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (CNT_W'(idx1_r) < cnt_r))
    else $error("scan read beyond stored points");

  a_out_empty_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !out_v_r)
    else $error("result register occupied during scan");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE && !pipe_busy))
    else $error("command taken while scan in progress");

endmodule

// File: hw/rtl/nearest_point_search_table_top.sv
// Top level of the nearest point search table.
//
//  channel | dir | tdata (low bit first)                       | tuser
//  in_     | in  | coord_x[15:0] coord_y[31:16] coord_z[47:32] | action[1:0]
//  out_    | out | nearest_index[7:0] min_dist_sq[41:8] pad    | found[0] status[1]
//
// Add, clear and unused actions are answered from the idle state once dequeued.
// A find on N stored points reads the point store once per cycle for each point,
// then a four-stage distance and compare pipeline drains.
// Reset empties the table and the command queue; the point store is not cleared.
// The front accepts while the back is busy until the two-entry command queue
// and its holding register fill; a stalled result blocks the next command.
module nearest_point_search_table_top #(
  parameter int MAX_POINTS = npst_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [npst_pkg::TDATA_IN_W-1:0]       in_tdata,   // coord_x, coord_y, coord_z
  input  logic [npst_pkg::ACT_W-1:0]            in_tuser,   // action
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [npst_pkg::TDATA_OUT_W-1:0]      out_tdata,  // nearest_index, min_dist_sq
  output logic [npst_pkg::TUSER_OUT_W-1:0]      out_tuser   // found, status
);
  import npst_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    q_wdata;
  cmd_t    q_rdata;
  res_t    res;

  npst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  npst_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  npst_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .res       (res)
  );

  assign out_tdata = {{(TDATA_OUT_W - IDX_OUT_W - DIST_W){1'b0}},
                      res.min_dist_sq, res.nearest_index};
  assign out_tuser = {res.status, res.found};

endmodule

// File: sim/tb_nearest_point_search_table_top.sv
// Self-checking testbench for the nearest point search table on its stream ports.
`timescale 1ns / 100ps

module tb_nearest_point_search_table_top;
  import npst_pkg::*;

  localparam int TBL_DEPTH = MAX_POINTS_DEF;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [TDATA_IN_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;
  logic [TUSER_OUT_W-1:0] out_tuser;

  nearest_point_search_table_top #(.MAX_POINTS(TBL_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the point table, updated as each transaction is accepted.
  logic signed [COORD_W-1:0] tbl_x [TBL_DEPTH];
  logic signed [COORD_W-1:0] tbl_y [TBL_DEPTH];
  logic signed [COORD_W-1:0] tbl_z [TBL_DEPTH];
  int                        tbl_count = 0;

  res_t pending_answers[$];
  int   err_cnt        = 0;
  bit   steady         = 1'b0;  // no idling on either side
  int   long_hold_req  = 0;
  int   stall_left     = 0;

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endfunction

  function automatic longint sq_dist(logic signed [COORD_W-1:0] ax, ay, az,
                                     logic signed [COORD_W-1:0] bx, by, bz);
    longint dx, dy, dz;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Apply one command to the shadow table and return the answer it must produce.
  function automatic res_t predict_answer(cmd_kind_t kind,
                                          logic signed [COORD_W-1:0] x, y, z);
    res_t   r;
    longint best, d;
    bit     seen;
    r    = '0;
    best = 0;
    seen = 1'b0;
    case (kind)
      CMD_ADD: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.status = 1'b1;
        end else begin
          tbl_x[tbl_count] = x;
          tbl_y[tbl_count] = y;
          tbl_z[tbl_count] = z;
          r.nearest_index  = IDX_OUT_W'(tbl_count);
          r.found          = 1'b1;
          tbl_count++;
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < tbl_count; i++) begin
          d = sq_dist(x, y, z, tbl_x[i], tbl_y[i], tbl_z[i]);
          // strict compare keeps the lowest index on a tie
          if (!seen || d < best) begin
            seen            = 1'b1;
            best            = d;
            r.nearest_index = IDX_OUT_W'(i);
          end
        end
        r.found       = seen;
        r.min_dist_sq = DIST_W'(best);
      end
      CMD_CLEAR: tbl_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // Result side: random stalls, long hold-off on request, and answer checking.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        note_error($sformatf("unexpected result tdata=%h tuser=%b", out_tdata, out_tuser));
      end else begin
        res_t exp_r;
        exp_r = pending_answers.pop_front();
        if (out_tdata[IDX_OUT_W-1:0] !== exp_r.nearest_index ||
            out_tdata[IDX_OUT_W +: DIST_W] !== exp_r.min_dist_sq ||
            out_tuser[0] !== exp_r.found || out_tuser[1] !== exp_r.status)
          note_error($sformatf(
            "mismatch: exp idx=%0d f=%0b s=%0b d=%0d, got idx=%0d f=%0b s=%0b d=%0d",
            exp_r.nearest_index, exp_r.found, exp_r.status, exp_r.min_dist_sq,
            out_tdata[IDX_OUT_W-1:0], out_tuser[0], out_tuser[1],
            out_tdata[IDX_OUT_W +: DIST_W]));
      end
    end
    if (long_hold_req > 0) begin
      stall_left    = long_hold_req;
      long_hold_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && !steady && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic pause_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one command; valid stays high until the next pause.
  task automatic send_cmd(cmd_kind_t kind, logic signed [COORD_W-1:0] x, y, z);
    if (!steady && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 8));
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(predict_answer(kind, x, y, z));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      5, 6, 7: return COORD_W'(int'($urandom_range(0, 40)) - 20);
      8:       return 16'sh7FFF;
      9:       return 16'sh8000;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(CMD_FIND, 0, 0, 0);                       // empty table
    send_cmd(CMD_NOP, -1, -1, -1);                     // unused action
    send_cmd(CMD_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_cmd(CMD_ADD, 16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(CMD_FIND, 16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(CMD_FIND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_cmd(CMD_FIND, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 0, 0);                        // duplicate point
    send_cmd(CMD_FIND, 0, 0, 0);                       // tie, lower index wins
    send_cmd(CMD_ADD, 1, 0, 0);
    send_cmd(CMD_ADD, -1, 0, 0);
    send_cmd(CMD_FIND, 0, 0, 0);
    send_cmd(CMD_FIND, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_cmd(CMD_FIND, 0, 5, 0);                       // equal distances to 1 and -1 in x
    send_cmd(CMD_CLEAR, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_cmd(CMD_FIND, 0, 0, 0);
    send_cmd(CMD_ADD, 16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(CMD_FIND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF); // largest distance
    send_cmd(CMD_NOP, 16'sh7FFF, 16'sh8000, 0);
    send_cmd(CMD_FIND, 16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(CMD_CLEAR, 0, 0, 0);
  endtask

  task automatic test_table_full();
    int k;
    send_cmd(CMD_CLEAR, 0, 0, 0);
    while (tbl_count < TBL_DEPTH) send_cmd(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
    send_cmd(CMD_ADD, 7, 7, 7);                        // refused
    send_cmd(CMD_ADD, -7, -7, -7);
    k = $urandom_range(0, TBL_DEPTH - 1);
    send_cmd(CMD_FIND, tbl_x[k], tbl_y[k], tbl_z[k]);
    send_cmd(CMD_FIND, tbl_x[TBL_DEPTH-1], tbl_y[TBL_DEPTH-1], tbl_z[TBL_DEPTH-1]);
    send_cmd(CMD_FIND, rand_coord(), rand_coord(), rand_coord());
    send_cmd(CMD_NOP, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    send_cmd(CMD_ADD, 3, 2, 1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    long_hold_req = 300;
    @(posedge clk);
    @(posedge clk);
    // keep offering while the result side is held off
    for (int i = 0; i < 14; i++) begin
      if (i % 3 == 2) send_cmd(CMD_FIND, rand_coord(), rand_coord(), rand_coord());
      else            send_cmd(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
    end
    wait_drained();
  endtask

  task automatic random_cmd();
    int                        r, k;
    logic signed [COORD_W-1:0] x, y, z;
    r = $urandom_range(0, 99);
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    if (r < 48) begin
      send_cmd(CMD_ADD, x, y, z);
    end else if (r < 93) begin
      // aim near a stored point half of the time
      if (tbl_count > 0 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, tbl_count - 1);
        x = tbl_x[k] + COORD_W'(int'($urandom_range(0, 2)) - 1);
        y = tbl_y[k];
        z = tbl_z[k] + COORD_W'(int'($urandom_range(0, 2)) - 1);
      end
      send_cmd(CMD_FIND, x, y, z);
    end else if (r < 95) begin
      send_cmd(CMD_CLEAR, x, y, z);
    end else begin
      send_cmd(CMD_NOP, x, y, z);
    end
  endtask

  task automatic test_random_traffic(int n_items);
    for (int i = 0; i < n_items; i++) begin
      random_cmd();
      if (i == n_items / 2) wait_drained();
    end
  endtask

  task automatic test_steady_stream(int n_items);
    steady = 1'b1;
    for (int i = 0; i < n_items; i++) random_cmd();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_traffic(720);
    test_steady_stream(150);
    wait_drained();
    repeat (50) @(posedge clk);
    if (pending_answers.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_answers.size()));
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
